// ===== rtl/nss_pkg.sv =====
package nss_pkg;

  // coordinate and result widths
  localparam int COORD_BITS      = 20;
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int CNT_W           = 6;
  localparam int IDX_W           = 5;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int SQ_W            = 2 * COORD_BITS + 2;
  localparam int ROOT_W          = SQ_W / 2;
  localparam int ENTRY_W         = 3 * COORD_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_IN_USE = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  // travels alongside each scanned entry through the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [CNT_W-1:0] idx;
  } scan_tag_t;

endpackage

// ===== rtl/nss_table.sv =====
module nss_table #(
  parameter int DEPTH = nss_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [nss_pkg::ENTRY_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [nss_pkg::ENTRY_W-1:0] rd_data
);

  logic [nss_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [nss_pkg::ENTRY_W-1:0] rd_data_r;

  // writes and reads never target the same entry in one cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/nss_dist.sv =====
module nss_dist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [nss_pkg::COORD_BITS-1:0] qry_x,
  input  logic signed [nss_pkg::COORD_BITS-1:0] qry_y,
  input  logic signed [nss_pkg::COORD_BITS-1:0] qry_z,
  input  logic        [nss_pkg::ENTRY_W-1:0]    entry,
  input  nss_pkg::scan_tag_t                    tag_in,
  output logic        [nss_pkg::SQ_W-1:0]       sq_dist,
  output nss_pkg::scan_tag_t                    tag_out
);

  localparam int C   = nss_pkg::COORD_BITS;
  localparam int P_W = 2 * C;

  function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
    logic [C:0] d;
    d = {a[C-1], a} - {b[C-1], b};
    if (d[C]) begin
      abs_diff = C'(-d);
    end else begin
      abs_diff = C'(d);
    end
  endfunction

  logic [C-1:0]            ax_r, ay_r, az_r;
  logic [P_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic [nss_pkg::SQ_W-1:0] sum_r;
  nss_pkg::scan_tag_t      tag1_r, tag2_r, tag3_r;

  // stage 1 magnitudes, stage 2 squares, stage 3 sum
  always_ff @(posedge clk) begin
    ax_r  <= abs_diff(qry_x, entry[3*C-1:2*C]);
    ay_r  <= abs_diff(qry_y, entry[2*C-1:C]);
    az_r  <= abs_diff(qry_z, entry[C-1:0]);
    sqx_r <= P_W'(ax_r) * P_W'(ax_r);
    sqy_r <= P_W'(ay_r) * P_W'(ay_r);
    sqz_r <= P_W'(az_r) * P_W'(az_r);
    sum_r <= nss_pkg::SQ_W'(sqx_r) + nss_pkg::SQ_W'(sqy_r) + nss_pkg::SQ_W'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  assign sq_dist = sum_r;
  assign tag_out = tag3_r;

endmodule

// ===== rtl/nss_isqrt.sv =====
module nss_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [nss_pkg::SQ_W-1:0]     operand,
  output logic                         done,
  output logic [nss_pkg::ROOT_W-1:0]   root
);

  localparam int SW    = nss_pkg::SQ_W;
  localparam int RW    = nss_pkg::ROOT_W;
  localparam int REM_W = RW + 3;
  localparam int CW    = $clog2(RW);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [SW-1:0]     op_r;
  logic [REM_W-1:0]  rem_r;
  logic [RW-1:0]     root_r;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // one root bit per cycle, two operand bits shifted in
  assign rem_sh = {rem_r[REM_W-3:0], op_r[SW-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      op_r   <= op_r << 2;
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/nearest_sensor_search_top.sv =====
// nearest-sensor search over a table of up to MAX_ENTRIES sensor positions
// (x, y, z signed fixed point, 0.01 cm). a transaction is taken at a clock
// edge with start high and busy low; its single result shows on the out_
// ports for exactly one cycle with out_valid high, and the receiver cannot
// stall it, so sample every cycle out_valid is high. cfg_wdata sets
// channel_count (entries in use, clamped to MAX_ENTRIES); write it only while
// busy is low and no result is pending. write, unused op, bad read index and
// empty query register their result at the accepting edge with busy staying
// low; a read goes through the registered table read and then S_RDATA; a
// query does one table read per entry, runs the 4-deep read/distance
// pipeline, then a bit-serial square root. an entry must be written before a
// read or query touches it
module nearest_sensor_search_top #(
  parameter int MAX_ENTRIES = nss_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic        [nss_pkg::CNT_W-1:0]      cfg_wdata,
  // command transaction
  input  logic                                  start,
  output logic                                  busy,
  input  logic        [nss_pkg::OP_W-1:0]       in_operation,
  input  logic        [nss_pkg::IDX_W-1:0]      in_entry_index,
  input  logic signed [nss_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [nss_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [nss_pkg::COORD_BITS-1:0] in_coord_z,
  // result transaction
  output logic                                  out_valid,
  output logic        [nss_pkg::STATUS_W-1:0]   out_status,
  output logic        [nss_pkg::IDX_W-1:0]      out_nearest_index,
  output logic        [nss_pkg::SQ_W-1:0]       out_squared_distance,
  output logic        [nss_pkg::ROOT_W-1:0]     out_distance,
  output logic signed [nss_pkg::COORD_BITS-1:0] out_read_x,
  output logic signed [nss_pkg::COORD_BITS-1:0] out_read_y,
  output logic signed [nss_pkg::COORD_BITS-1:0] out_read_z
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int C  = nss_pkg::COORD_BITS;
  localparam int CW = nss_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_SCAN,
    S_DRAIN,
    S_LAUNCH,
    S_ROOT
  } state_t;

  state_t                         state_r;
  logic [CW-1:0]                  count_cfg_r;
  logic [CW-1:0]                  scan_r;
  nss_pkg::scan_tag_t             tag_r;
  logic signed [C-1:0]            qx_r, qy_r, qz_r;
  logic [nss_pkg::SQ_W-1:0]       best_r;
  logic [CW-1:0]                  best_idx_r;

  // registered result transaction
  logic                           out_valid_r;
  nss_pkg::status_t               out_status_r;
  logic [nss_pkg::IDX_W-1:0]      out_index_r;
  logic [nss_pkg::SQ_W-1:0]       out_sq_r;
  logic [nss_pkg::ROOT_W-1:0]     out_dist_r;
  logic signed [C-1:0]            out_rx_r, out_ry_r, out_rz_r;

  logic [CW-1:0]                  eff_count;
  logic                           accept;
  nss_pkg::op_t                   op;
  logic                           read_ok;
  logic                           scan_last;

  // table port
  logic                           mem_we;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [nss_pkg::ENTRY_W-1:0]    mem_rdata;

  // distance pipeline and root unit
  logic [nss_pkg::SQ_W-1:0]       dist_sq;
  nss_pkg::scan_tag_t             dist_tag;
  logic                           root_start;
  logic                           root_done;
  logic [nss_pkg::ROOT_W-1:0]     root_val;

  // entries in use, never more than the table holds
  always_comb begin
    if (32'(count_cfg_r) > MAX_ENTRIES) begin
      eff_count = CW'(MAX_ENTRIES);
    end else begin
      eff_count = count_cfg_r;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign op        = nss_pkg::op_t'(in_operation);
  assign read_ok   = (CW'(in_entry_index) < eff_count);
  assign scan_last = (scan_r == eff_count - CW'(1));

  // writes land only on an idle accept, scan reads only while busy
  assign mem_we    = accept && (op == nss_pkg::OP_WRITE) && (32'(in_entry_index) < MAX_ENTRIES);
  assign mem_re    = (accept && (op == nss_pkg::OP_READ)) || (state_r == S_SCAN);
  assign mem_raddr = (state_r == S_SCAN) ? AW'(scan_r) : AW'(in_entry_index);

  assign root_start = (state_r == S_LAUNCH);

  nss_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (AW'(in_entry_index)),
    .wr_data ({in_coord_x, in_coord_y, in_coord_z}),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  nss_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .qry_x   (qx_r),
    .qry_y   (qy_r),
    .qry_z   (qz_r),
    .entry   (mem_rdata),
    .tag_in  (tag_r),
    .sq_dist (dist_sq),
    .tag_out (dist_tag)
  );

  nss_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (root_start),
    .operand (best_r),
    .done    (root_done),
    .root    (root_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_cfg_r  <= '0;
      scan_r       <= '0;
      tag_r        <= '0;
      qx_r         <= '0;
      qy_r         <= '0;
      qz_r         <= '0;
      best_r       <= '0;
      best_idx_r   <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= nss_pkg::ST_OK;
      out_index_r  <= '0;
      out_sq_r     <= '0;
      out_dist_r   <= '0;
      out_rx_r     <= '0;
      out_ry_r     <= '0;
      out_rz_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      tag_r       <= '0;

      if (cfg_we) begin
        count_cfg_r <= cfg_wdata;
      end

      // running minimum, first index wins on ties
      if (dist_tag.valid && ((dist_tag.idx == '0) || (dist_sq < best_r))) begin
        best_r     <= dist_sq;
        best_idx_r <= dist_tag.idx;
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            qx_r         <= in_coord_x;
            qy_r         <= in_coord_y;
            qz_r         <= in_coord_z;
            out_status_r <= nss_pkg::ST_OK;
            out_index_r  <= '0;
            out_sq_r     <= '0;
            out_dist_r   <= '0;
            out_rx_r     <= '0;
            out_ry_r     <= '0;
            out_rz_r     <= '0;
            unique case (op)
              nss_pkg::OP_WRITE, nss_pkg::OP_NONE: begin
                out_valid_r <= 1'b1;
              end
              nss_pkg::OP_READ: begin
                if (read_ok) begin
                  state_r <= S_RDATA;
                end else begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= nss_pkg::ST_NOT_IN_USE;
                end
              end
              nss_pkg::OP_QUERY: begin
                if (eff_count == '0) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= nss_pkg::ST_EMPTY;
                end else begin
                  scan_r  <= '0;
                  state_r <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_RDATA: begin
          out_valid_r <= 1'b1;
          out_rx_r    <= mem_rdata[3*C-1:2*C];
          out_ry_r    <= mem_rdata[2*C-1:C];
          out_rz_r    <= mem_rdata[C-1:0];
          state_r     <= S_IDLE;
        end
        S_SCAN: begin
          // one entry read per cycle, its tag registered in step with the table read data
          tag_r.valid <= 1'b1;
          tag_r.last  <= scan_last;
          tag_r.idx   <= scan_r;
          scan_r      <= scan_r + CW'(1);
          if (scan_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (dist_tag.valid && dist_tag.last) begin
            state_r <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            out_valid_r  <= 1'b1;
            out_status_r <= nss_pkg::ST_OK;
            out_index_r  <= nss_pkg::IDX_W'(best_idx_r);
            out_sq_r     <= best_r;
            out_dist_r   <= root_val;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_nearest_index    = out_index_r;
  assign out_squared_distance = out_sq_r;
  assign out_distance         = out_dist_r;
  assign out_read_x           = out_rx_r;
  assign out_read_y           = out_ry_r;
  assign out_read_z           = out_rz_r;

  // a result only ever appears once the block has gone idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // distance results only flow while a query scan is in progress
  a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dist_tag.valid |-> ((state_r == S_SCAN) || (state_r == S_DRAIN)))
    else $error("distance result outside a query scan");

  // root unit returns the floor square root of the minimum
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> ((64'(root_val) * 64'(root_val) <= 64'(best_r)) &&
                   ((64'(root_val) + 64'd1) * (64'(root_val) + 64'd1) > 64'(best_r))))
    else $error("square root out of range");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nss_pkg::*;

  localparam int MAX_ENTRIES     = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 80;    // outlasts the longest query
  localparam int RANDOM_COMMANDS = 1900;
  localparam int QUIET_TAIL      = 150;   // last commands go without gaps

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // what the stimulus queue carries: a command, a channel count write, or a
  // pause that lets every outstanding result come back first
  typedef enum logic [1:0] {
    SLOT_CMD,
    SLOT_CFG,
    SLOT_PAUSE
  } slot_kind_t;

  typedef struct {
    slot_kind_t                   kind;
    int                           gap;    // idle cycles ahead of this command
    op_t                          op;
    logic [IDX_W-1:0]             idx;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [CNT_W-1:0]             count;
  } slot_t;

  // one predicted search answer, same fields as the result ports
  typedef struct {
    status_t                      status;
    logic [IDX_W-1:0]             nearest;
    logic [SQ_W-1:0]              sq_dist;
    logic [ROOT_W-1:0]            root;
    logic signed [COORD_BITS-1:0] rd_x;
    logic signed [COORD_BITS-1:0] rd_y;
    logic signed [COORD_BITS-1:0] rd_z;
  } answer_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // dut inputs, all known from time zero
  logic                         cfg_we         = 1'b0;
  logic [CNT_W-1:0]             cfg_wdata      = '0;
  logic                         start          = 1'b0;
  logic [OP_W-1:0]              in_operation   = '0;
  logic [IDX_W-1:0]             in_entry_index = '0;
  logic signed [COORD_BITS-1:0] in_coord_x     = '0;
  logic signed [COORD_BITS-1:0] in_coord_y     = '0;
  logic signed [COORD_BITS-1:0] in_coord_z     = '0;

  // dut outputs
  logic                         busy;
  logic                         out_valid;
  logic [STATUS_W-1:0]          out_status;
  logic [IDX_W-1:0]             out_nearest_index;
  logic [SQ_W-1:0]              out_squared_distance;
  logic [ROOT_W-1:0]            out_distance;
  logic signed [COORD_BITS-1:0] out_read_x;
  logic signed [COORD_BITS-1:0] out_read_y;
  logic signed [COORD_BITS-1:0] out_read_z;

  // stimulus and prediction state
  slot_t   command_q[$];
  answer_t answer_q[$];
  int      commands_left  = 0;   // commands not yet taken by the dut
  int      mismatch_count = 0;
  int      cycle_count    = 0;

  // predicted sensor table and channel count
  logic signed [COORD_BITS-1:0] pos_x [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] pos_y [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] pos_z [MAX_ENTRIES];
  int unsigned                  model_count = 0;

  // positions as planned while the stimulus is built, used to aim queries
  logic signed [COORD_BITS-1:0] planned_x [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] planned_y [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] planned_z [MAX_ENTRIES];
  int                           gen_count    = 0;
  int                           gen_idle_pct = 0;
  logic                         gen_quiet    = 1'b0;

  // driver state
  slot_t active_cmd;
  logic  taken;
  logic  hold_cmd;
  logic  start_next;
  logic  we_next;
  logic  gap_served = 1'b0;
  int    gap_left   = 0;

  answer_t oldest_answer;

  nearest_sensor_search_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_entry_index      (in_entry_index),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .in_coord_z          (in_coord_z),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_nearest_index   (out_nearest_index),
    .out_squared_distance(out_squared_distance),
    .out_distance        (out_distance),
    .out_read_x          (out_read_x),
    .out_read_y          (out_read_y),
    .out_read_z          (out_read_z)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one command to the predicted table and work out its answer
  function automatic answer_t search_table(input slot_t c);
    answer_t     a;
    int unsigned used;
    int          i;
    int          b;
    int          best_i;
    longint      dx;
    longint      dy;
    longint      dz;
    longint      d2;
    longint      best;
    longint      root;
    longint      trial;
    a.status  = ST_OK;
    a.nearest = '0;
    a.sq_dist = '0;
    a.root    = '0;
    a.rd_x    = '0;
    a.rd_y    = '0;
    a.rd_z    = '0;
    // counts above the table size behave like a full table
    used = (model_count > MAX_ENTRIES) ? MAX_ENTRIES : model_count;
    case (c.op)
      OP_WRITE: begin
        pos_x[c.idx] = c.x;
        pos_y[c.idx] = c.y;
        pos_z[c.idx] = c.z;
      end
      OP_QUERY: begin
        if (used == 0) begin
          a.status = ST_EMPTY;
        end else begin
          best   = 0;
          best_i = 0;
          for (i = 0; i < used; i++) begin
            dx = longint'(c.x) - longint'(pos_x[i]);
            dy = longint'(c.y) - longint'(pos_y[i]);
            dz = longint'(c.z) - longint'(pos_z[i]);
            d2 = dx * dx + dy * dy + dz * dz;
            // strict compare keeps the lower index on a tie
            if (i == 0 || d2 < best) begin
              best   = d2;
              best_i = i;
            end
          end
          // floor square root, one result bit at a time from the top
          root = 0;
          for (b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= best) begin
              root = trial;
            end
          end
          a.nearest = best_i[IDX_W-1:0];
          a.sq_dist = best[SQ_W-1:0];
          a.root    = root[ROOT_W-1:0];
        end
      end
      OP_READ: begin
        if (c.idx >= used) begin
          a.status = ST_NOT_IN_USE;
        end else begin
          a.rd_x = pos_x[c.idx];
          a.rd_y = pos_y[c.idx];
          a.rd_z = pos_z[c.idx];
        end
      end
      default: begin
        // unused op code leaves everything alone
      end
    endcase
    return a;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("[%0t] %s: got %0h, predicted %0h", $time, what, got, want);
  endtask

  // coordinate mix: extremes now and then, small values, full range
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    logic signed [COORD_BITS-1:0] c;
    case ($urandom_range(0, 9))
      0:       c = C_MAX;
      1:       c = C_MIN;
      2:       c = '0;
      3, 4:    c = COORD_BITS'($urandom_range(0, 2000)) - COORD_BITS'(1000);
      default: c = COORD_BITS'($urandom);
    endcase
    return c;
  endfunction

  // point near a given coordinate, wrapping at the field width
  function automatic logic signed [COORD_BITS-1:0] jitter(
    input logic signed [COORD_BITS-1:0] c, input int span);
    return c + COORD_BITS'($urandom_range(0, 2 * span)) - COORD_BITS'(span);
  endfunction

  task automatic queue_cmd(input op_t op, input int idx,
                           input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y,
                           input logic signed [COORD_BITS-1:0] z);
    slot_t s;
    s.kind  = SLOT_CMD;
    s.gap   = (!gen_quiet && $urandom_range(0, 99) < gen_idle_pct) ?
              $urandom_range(1, 15) : 0;
    s.op    = op;
    s.idx   = idx[IDX_W-1:0];
    s.x     = x;
    s.y     = y;
    s.z     = z;
    s.count = '0;
    if (op == OP_WRITE) begin
      planned_x[idx] = x;
      planned_y[idx] = y;
      planned_z[idx] = z;
    end
    command_q = {command_q, s};
    commands_left++;
  endtask

  // channel count write or plain pause, both wait for an idle block
  task automatic queue_control(input slot_kind_t k, input int n);
    slot_t s;
    s.kind  = k;
    s.gap   = 0;
    s.op    = OP_NONE;
    s.idx   = '0;
    s.x     = '0;
    s.y     = '0;
    s.z     = '0;
    s.count = n[CNT_W-1:0];
    if (k == SLOT_CFG) begin
      gen_count = n;
    end
    command_q = {command_q, s};
  endtask

  // driver: one nonblocking update per signal per edge
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      taken      = start && !busy;
      hold_cmd   = start && busy;
      start_next = hold_cmd;
      we_next    = 1'b0;
      if (taken) begin
        // transaction accepted at this edge, predict its answer now
        answer_q = {answer_q, search_table(active_cmd)};
        commands_left--;
      end
      if (!hold_cmd) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (command_q.size() != 0) begin
          if (command_q[0].kind == SLOT_CMD) begin
            if (command_q[0].gap > 0 && !gap_served) begin
              // this cycle is the first of the gap
              gap_left   = command_q[0].gap - 1;
              gap_served = 1'b1;
            end else begin
              active_cmd = command_q.pop_front();
              gap_served = 1'b0;
              start_next = 1'b1;
            end
          end else if (answer_q.size() == 0 && !busy) begin
            // block idle with nothing outstanding
            if (command_q[0].kind == SLOT_CFG) begin
              we_next     = 1'b1;
              cfg_wdata   <= command_q[0].count;
              model_count = command_q[0].count;
            end
            void'(command_q.pop_front());
          end
        end
      end
      start  <= start_next;
      cfg_we <= we_next;
      if (start_next && !hold_cmd) begin
        in_operation   <= active_cmd.op;
        in_entry_index <= active_cmd.idx;
        in_coord_x     <= active_cmd.x;
        in_coord_y     <= active_cmd.y;
        in_coord_z     <= active_cmd.z;
      end
    end
  end

  // monitor: results cannot be held off, so check every strobe
  always @(posedge clk) begin : monitor
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        flag_mismatch("result with no command outstanding", out_status, '0);
      end else begin
        oldest_answer = answer_q.pop_front();
        if (out_status !== oldest_answer.status) begin
          flag_mismatch("status", out_status, oldest_answer.status);
        end
        if (out_nearest_index !== oldest_answer.nearest) begin
          flag_mismatch("nearest_index", out_nearest_index, oldest_answer.nearest);
        end
        if (out_squared_distance !== oldest_answer.sq_dist) begin
          flag_mismatch("squared_distance", out_squared_distance, oldest_answer.sq_dist);
        end
        if (out_distance !== oldest_answer.root) begin
          flag_mismatch("distance", out_distance, oldest_answer.root);
        end
        if (out_read_x !== oldest_answer.rd_x) begin
          flag_mismatch("read_x", out_read_x, oldest_answer.rd_x);
        end
        if (out_read_y !== oldest_answer.rd_y) begin
          flag_mismatch("read_y", out_read_y, oldest_answer.rd_y);
        end
        if (out_read_z !== oldest_answer.rd_z) begin
          flag_mismatch("read_z", out_read_z, oldest_answer.rd_z);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int generated;
    int phase;
    int len;
    int j;
    int w;
    int k;
    int other;
    int n;
    int used;
    int pick;
    int span;

    // directed: empty table, reads with nothing in use and an unused op
    gen_idle_pct = 20;
    queue_cmd(OP_QUERY, 0, '0, '0, '0);
    queue_cmd(OP_READ, 0, '0, '0, '0);
    queue_cmd(OP_READ, 31, C_MAX, C_MIN, C_MAX);
    queue_cmd(OP_NONE, 31, C_MAX, C_MIN, C_MAX);
    // extreme corners, the origin, and a point tied with the origin
    queue_cmd(OP_WRITE, 0, C_MAX, C_MAX, C_MAX);
    queue_cmd(OP_WRITE, 1, C_MIN, C_MIN, C_MIN);
    queue_cmd(OP_WRITE, 2, '0, '0, '0);
    queue_cmd(OP_WRITE, 3, 20'sd2, -20'sd2, '0);
    // one entry in use: largest possible distance, then a read in use and one past the count
    queue_control(SLOT_CFG, 1);
    queue_cmd(OP_QUERY, 17, C_MIN, C_MIN, C_MIN);
    queue_cmd(OP_READ, 0, '0, '0, '0);
    queue_cmd(OP_READ, 1, '0, '0, '0);
    // four in use: tie goes to the lower index, exact hit, distance one
    queue_control(SLOT_CFG, 4);
    queue_cmd(OP_QUERY, 0, 20'sd1, -20'sd1, '0);
    queue_cmd(OP_QUERY, 31, C_MIN, C_MIN, C_MIN);
    queue_cmd(OP_QUERY, 5, C_MAX, C_MAX, C_MAX - 20'sd1);
    queue_cmd(OP_READ, 3, '0, '0, '0);
    queue_cmd(OP_READ, 4, '0, '0, '0);
    queue_cmd(OP_NONE, 0, '0, '0, '0);
    // sender waits for every result before going on
    queue_control(SLOT_PAUSE, 0);

    // random part starts by filling the whole table so nothing stale is read
    generated = 0;
    for (w = 0; w < MAX_ENTRIES; w++) begin
      queue_cmd(OP_WRITE, w, rand_coord(), rand_coord(), rand_coord());
      generated++;
    end

    phase = 0;
    while (generated < RANDOM_COMMANDS) begin
      // first phases hit the count extremes, including past the table size
      case (phase)
        0:       n = 32;
        1:       n = 63;
        2:       n = 0;
        3:       n = 1;
        4:       n = 33;
        default: n = $urandom_range(0, 63);
      endcase
      queue_control(SLOT_CFG, n);
      case ($urandom_range(0, 3))
        0:       gen_idle_pct = 0;
        1:       gen_idle_pct = 10;
        2:       gen_idle_pct = 30;
        default: gen_idle_pct = 60;
      endcase
      len  = $urandom_range(40, 160);
      used = (gen_count > MAX_ENTRIES) ? MAX_ENTRIES : gen_count;
      for (j = 0; j < len && generated < RANDOM_COMMANDS; j++) begin
        gen_quiet = (generated >= RANDOM_COMMANDS - QUIET_TAIL);
        pick = $urandom_range(0, 99);
        k    = (used > 0) ? $urandom_range(0, used - 1) : $urandom_range(0, MAX_ENTRIES - 1);
        case ($urandom_range(0, 2))
          0:       span = 0;
          1:       span = 3;
          default: span = 400;
        endcase
        if (pick < 40) begin
          // queries mostly aimed near an entry in use
          if ($urandom_range(0, 2) != 0) begin
            queue_cmd(OP_QUERY, $urandom_range(0, 31), jitter(planned_x[k], span),
                      jitter(planned_y[k], span), jitter(planned_z[k], span));
          end else begin
            queue_cmd(OP_QUERY, $urandom_range(0, 31), rand_coord(), rand_coord(),
                      rand_coord());
          end
        end else if (pick < 65) begin
          w     = $urandom_range(0, MAX_ENTRIES - 1);
          other = $urandom_range(0, MAX_ENTRIES - 1);
          case ($urandom_range(0, 3))
            // duplicate of another entry makes ties likely
            0: queue_cmd(OP_WRITE, w, planned_x[other], planned_y[other], planned_z[other]);
            1: queue_cmd(OP_WRITE, w, jitter(planned_x[other], span),
                         jitter(planned_y[other], span), jitter(planned_z[other], span));
            default: queue_cmd(OP_WRITE, w, rand_coord(), rand_coord(), rand_coord());
          endcase
        end else if (pick < 95) begin
          w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_ENTRIES - 1) : k;
          queue_cmd(OP_READ, w, rand_coord(), rand_coord(), rand_coord());
        end else begin
          queue_cmd(OP_NONE, $urandom_range(0, 31), rand_coord(), rand_coord(),
                    rand_coord());
        end
        generated++;
        // now and then the sender waits for every result before going on
        if (!gen_quiet && $urandom_range(0, 99) == 0) begin
          queue_control(SLOT_PAUSE, 0);
        end
      end
      phase++;
    end

    // hold reset, then release
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (commands_left != 0 || answer_q.size() != 0) begin
      @(posedge clk);
    end
    // catch any stray result after the last one
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
